>>> rtl/core/obb_sat_pkg.sv
// shared widths, axis codes and stage payload types of the oriented box overlap test
`default_nettype none

package obb_sat_pkg;

   localparam int COORD_W    = 24;
   localparam int HALF_W     = 23;
   localparam int DIR_W      = 16;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int DIR_PROD_W = 2 * DIR_W;
   localparam int DOT_W      = 2 * DIR_W;
   localparam int D_PROD_W   = DIR_W + DIFF_W;
   localparam int D_MAG_W    = D_PROD_W;
   localparam int E_PROD_W   = DOT_W + HALF_W;
   localparam int CMP_W      = E_PROD_W + 2;
   localparam int DIST_SHIFT = 14;
   localparam int AXIS_W     = 3;
   localparam int NUM_AXES   = 4;

   localparam logic [AXIS_W-1:0] AXIS_A_RIGHT = 3'd0;
   localparam logic [AXIS_W-1:0] AXIS_A_UP    = 3'd1;
   localparam logic [AXIS_W-1:0] AXIS_B_RIGHT = 3'd2;
   localparam logic [AXIS_W-1:0] AXIS_B_UP    = 3'd3;
   localparam logic [AXIS_W-1:0] AXIS_NONE    = 3'd4;

   // direction dot magnitudes, center distance products and half sizes
   typedef struct packed {
      logic [DOT_W-1:0]           n_a;
      logic [DOT_W-1:0]           n_b;
      logic [DOT_W-1:0]           p;
      logic [DOT_W-1:0]           q;
      logic signed [D_PROD_W-1:0] ca_dx;
      logic signed [D_PROD_W-1:0] sa_dy;
      logic signed [D_PROD_W-1:0] sa_dx;
      logic signed [D_PROD_W-1:0] ca_dy;
      logic signed [D_PROD_W-1:0] cb_dx;
      logic signed [D_PROD_W-1:0] sb_dy;
      logic signed [D_PROD_W-1:0] sb_dx;
      logic signed [D_PROD_W-1:0] cb_dy;
      logic [HALF_W-1:0]          half_w_a;
      logic [HALF_W-1:0]          half_h_a;
      logic [HALF_W-1:0]          half_w_b;
      logic [HALF_W-1:0]          half_h_b;
   } front_out_type;

   // per axis distance and extent, both at scale 2^-28
   typedef struct packed {
      logic [NUM_AXES-1:0][CMP_W-1:0] center_dist;
      logic [NUM_AXES-1:0][CMP_W-1:0] ext;
   } proj_out_type;

endpackage

`default_nettype wire

>>> rtl/core/obb_separating_axis_test.sv
// top level of the pipelined 2d oriented box separating axis test
`default_nettype none

// Takes one pair of oriented rectangles per beat on start and returns one
// beat on rsp_valid after the five registered stages; a new pair may enter every
// cycle, so busy stays low and results stream out in order at one per cycle.
// The five stages are the direction products, the dot magnitudes with the
// center distance products, the extent products, the extent sums, and the
// four axis compares with the priority pick. The receiver cannot stall, so
// each result is shown for one cycle only and must be taken then.

module obb_separating_axis_test
   import obb_sat_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_a_center_x,
   input  logic signed [COORD_W-1:0] req_a_center_y,
   input  logic [HALF_W-1:0]         req_a_half_w,
   input  logic [HALF_W-1:0]         req_a_half_h,
   input  logic signed [DIR_W-1:0]   req_a_cos,
   input  logic signed [DIR_W-1:0]   req_a_sin,
   input  logic signed [COORD_W-1:0] req_b_center_x,
   input  logic signed [COORD_W-1:0] req_b_center_y,
   input  logic [HALF_W-1:0]         req_b_half_w,
   input  logic [HALF_W-1:0]         req_b_half_h,
   input  logic signed [DIR_W-1:0]   req_b_cos,
   input  logic signed [DIR_W-1:0]   req_b_sin,
   output logic                      rsp_valid,
   output logic                      rsp_hit,
   output logic [AXIS_W-1:0]         rsp_sep_axis
);

   logic          accept;
   logic          front_valid;
   front_out_type front_out;
   logic          proj_valid;
   proj_out_type  proj_out;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   obb_sat_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .a_center_x (req_a_center_x),
      .a_center_y (req_a_center_y),
      .a_half_w   (req_a_half_w),
      .a_half_h   (req_a_half_h),
      .a_cos      (req_a_cos),
      .a_sin      (req_a_sin),
      .b_center_x (req_b_center_x),
      .b_center_y (req_b_center_y),
      .b_half_w   (req_b_half_w),
      .b_half_h   (req_b_half_h),
      .b_cos      (req_b_cos),
      .b_sin      (req_b_sin),
      .out_valid  (front_valid),
      .out        (front_out)
   );

   obb_sat_project u_project (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in        (front_out),
      .out_valid (proj_valid),
      .out       (proj_out)
   );

   obb_sat_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (proj_valid),
      .in        (proj_out),
      .out_valid (rsp_valid),
      .hit       (rsp_hit),
      .sep_axis  (rsp_sep_axis)
   );

endmodule

`default_nettype wire

>>> rtl/core/obb_sat_front.sv
// stages one and two: direction products, center difference, dot magnitudes
`default_nettype none

module obb_sat_front
   import obb_sat_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic signed [COORD_W-1:0] a_center_x,
   input  logic signed [COORD_W-1:0] a_center_y,
   input  logic [HALF_W-1:0]         a_half_w,
   input  logic [HALF_W-1:0]         a_half_h,
   input  logic signed [DIR_W-1:0]   a_cos,
   input  logic signed [DIR_W-1:0]   a_sin,
   input  logic signed [COORD_W-1:0] b_center_x,
   input  logic signed [COORD_W-1:0] b_center_y,
   input  logic [HALF_W-1:0]         b_half_w,
   input  logic [HALF_W-1:0]         b_half_h,
   input  logic signed [DIR_W-1:0]   b_cos,
   input  logic signed [DIR_W-1:0]   b_sin,
   output logic                      out_valid,
   output front_out_type             out
);

   typedef struct packed {
      logic signed [DIR_W-1:0]      cos_a;
      logic signed [DIR_W-1:0]      sin_a;
      logic signed [DIR_W-1:0]      cos_b;
      logic signed [DIR_W-1:0]      sin_b;
      logic signed [DIFF_W-1:0]     dx;
      logic signed [DIFF_W-1:0]     dy;
      logic signed [DIR_PROD_W-1:0] aa_cc;
      logic signed [DIR_PROD_W-1:0] aa_ss;
      logic signed [DIR_PROD_W-1:0] bb_cc;
      logic signed [DIR_PROD_W-1:0] bb_ss;
      logic signed [DIR_PROD_W-1:0] ab_cc;
      logic signed [DIR_PROD_W-1:0] ab_ss;
      logic signed [DIR_PROD_W-1:0] ab_sc;
      logic signed [DIR_PROD_W-1:0] ab_cs;
      logic [HALF_W-1:0]            half_w_a;
      logic [HALF_W-1:0]            half_h_a;
      logic [HALF_W-1:0]            half_w_b;
      logic [HALF_W-1:0]            half_h_b;
   } s1_type;

   s1_type        s1_in, s1_ff;
   logic          s1_valid_in, s1_valid_ff;
   front_out_type s2_in, s2_ff;
   logic          s2_valid_in, s2_valid_ff;

   logic signed [DOT_W:0] n_a_sum;
   logic signed [DOT_W:0] n_b_sum;
   logic signed [DOT_W:0] p_sum;
   logic signed [DOT_W:0] q_sum;

   assign s1_valid_in = in_valid;
   assign s2_valid_in = s1_valid_ff;

   always_comb begin
      s1_in.cos_a    = a_cos;
      s1_in.sin_a    = a_sin;
      s1_in.cos_b    = b_cos;
      s1_in.sin_b    = b_sin;
      s1_in.dx       = DIFF_W'(a_center_x) - DIFF_W'(b_center_x);
      s1_in.dy       = DIFF_W'(a_center_y) - DIFF_W'(b_center_y);
      s1_in.aa_cc    = DIR_PROD_W'(a_cos) * DIR_PROD_W'(a_cos);
      s1_in.aa_ss    = DIR_PROD_W'(a_sin) * DIR_PROD_W'(a_sin);
      s1_in.bb_cc    = DIR_PROD_W'(b_cos) * DIR_PROD_W'(b_cos);
      s1_in.bb_ss    = DIR_PROD_W'(b_sin) * DIR_PROD_W'(b_sin);
      s1_in.ab_cc    = DIR_PROD_W'(a_cos) * DIR_PROD_W'(b_cos);
      s1_in.ab_ss    = DIR_PROD_W'(a_sin) * DIR_PROD_W'(b_sin);
      s1_in.ab_sc    = DIR_PROD_W'(a_sin) * DIR_PROD_W'(b_cos);
      s1_in.ab_cs    = DIR_PROD_W'(a_cos) * DIR_PROD_W'(b_sin);
      s1_in.half_w_a = a_half_w;
      s1_in.half_h_a = a_half_h;
      s1_in.half_w_b = b_half_w;
      s1_in.half_h_b = b_half_h;
   end

   always_comb begin
      n_a_sum = (DOT_W+1)'($signed(s1_ff.aa_cc)) + (DOT_W+1)'($signed(s1_ff.aa_ss));
      n_b_sum = (DOT_W+1)'($signed(s1_ff.bb_cc)) + (DOT_W+1)'($signed(s1_ff.bb_ss));
      p_sum   = (DOT_W+1)'($signed(s1_ff.ab_cc)) + (DOT_W+1)'($signed(s1_ff.ab_ss));
      q_sum   = (DOT_W+1)'($signed(s1_ff.ab_sc)) - (DOT_W+1)'($signed(s1_ff.ab_cs));

      // squared norms are never negative
      s2_in.n_a = DOT_W'(n_a_sum);
      s2_in.n_b = DOT_W'(n_b_sum);
      s2_in.p   = p_sum[DOT_W] ? DOT_W'(-p_sum) : DOT_W'(p_sum);
      s2_in.q   = q_sum[DOT_W] ? DOT_W'(-q_sum) : DOT_W'(q_sum);

      s2_in.ca_dx = D_PROD_W'($signed(s1_ff.cos_a)) * D_PROD_W'($signed(s1_ff.dx));
      s2_in.sa_dy = D_PROD_W'($signed(s1_ff.sin_a)) * D_PROD_W'($signed(s1_ff.dy));
      s2_in.sa_dx = D_PROD_W'($signed(s1_ff.sin_a)) * D_PROD_W'($signed(s1_ff.dx));
      s2_in.ca_dy = D_PROD_W'($signed(s1_ff.cos_a)) * D_PROD_W'($signed(s1_ff.dy));
      s2_in.cb_dx = D_PROD_W'($signed(s1_ff.cos_b)) * D_PROD_W'($signed(s1_ff.dx));
      s2_in.sb_dy = D_PROD_W'($signed(s1_ff.sin_b)) * D_PROD_W'($signed(s1_ff.dy));
      s2_in.sb_dx = D_PROD_W'($signed(s1_ff.sin_b)) * D_PROD_W'($signed(s1_ff.dx));
      s2_in.cb_dy = D_PROD_W'($signed(s1_ff.cos_b)) * D_PROD_W'($signed(s1_ff.dy));

      s2_in.half_w_a = s1_ff.half_w_a;
      s2_in.half_h_a = s1_ff.half_h_a;
      s2_in.half_w_b = s1_ff.half_w_b;
      s2_in.half_h_b = s1_ff.half_h_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   assign out_valid = s2_valid_ff;
   assign out       = s2_ff;

endmodule

`default_nettype wire

>>> rtl/core/obb_sat_project.sv
// stages three and four: projected distances and summed half extents per axis
`default_nettype none

module obb_sat_project
   import obb_sat_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  front_out_type in,
   output logic          out_valid,
   output proj_out_type  out
);

   typedef struct packed {
      logic [NUM_AXES-1:0][D_MAG_W-1:0] d_mag;
      logic [E_PROD_W-1:0] na_hwa;
      logic [E_PROD_W-1:0] na_hha;
      logic [E_PROD_W-1:0] nb_hwb;
      logic [E_PROD_W-1:0] nb_hhb;
      logic [E_PROD_W-1:0] p_hwa;
      logic [E_PROD_W-1:0] p_hha;
      logic [E_PROD_W-1:0] p_hwb;
      logic [E_PROD_W-1:0] p_hhb;
      logic [E_PROD_W-1:0] q_hwa;
      logic [E_PROD_W-1:0] q_hha;
      logic [E_PROD_W-1:0] q_hwb;
      logic [E_PROD_W-1:0] q_hhb;
   } s3_type;

   s3_type       s3_in, s3_ff;
   logic         s3_valid_in, s3_valid_ff;
   proj_out_type s4_in, s4_ff;
   logic         s4_valid_in, s4_valid_ff;

   logic signed [NUM_AXES-1:0][D_PROD_W:0] d_sum;

   assign s3_valid_in = in_valid;
   assign s4_valid_in = s3_valid_ff;

   always_comb begin
      // center offset along a right, a up, b right, b up
      d_sum[0] = (D_PROD_W+1)'($signed(in.ca_dx)) + (D_PROD_W+1)'($signed(in.sa_dy));
      d_sum[1] = (D_PROD_W+1)'($signed(in.ca_dy)) - (D_PROD_W+1)'($signed(in.sa_dx));
      d_sum[2] = (D_PROD_W+1)'($signed(in.cb_dx)) + (D_PROD_W+1)'($signed(in.sb_dy));
      d_sum[3] = (D_PROD_W+1)'($signed(in.cb_dy)) - (D_PROD_W+1)'($signed(in.sb_dx));
      for (int i = 0; i < NUM_AXES; i++) begin
         s3_in.d_mag[i] = d_sum[i][D_PROD_W] ? D_MAG_W'(-$signed(d_sum[i]))
                                             : D_MAG_W'(d_sum[i]);
      end

      s3_in.na_hwa = E_PROD_W'(in.n_a) * E_PROD_W'(in.half_w_a);
      s3_in.na_hha = E_PROD_W'(in.n_a) * E_PROD_W'(in.half_h_a);
      s3_in.nb_hwb = E_PROD_W'(in.n_b) * E_PROD_W'(in.half_w_b);
      s3_in.nb_hhb = E_PROD_W'(in.n_b) * E_PROD_W'(in.half_h_b);
      s3_in.p_hwa  = E_PROD_W'(in.p) * E_PROD_W'(in.half_w_a);
      s3_in.p_hha  = E_PROD_W'(in.p) * E_PROD_W'(in.half_h_a);
      s3_in.p_hwb  = E_PROD_W'(in.p) * E_PROD_W'(in.half_w_b);
      s3_in.p_hhb  = E_PROD_W'(in.p) * E_PROD_W'(in.half_h_b);
      s3_in.q_hwa  = E_PROD_W'(in.q) * E_PROD_W'(in.half_w_a);
      s3_in.q_hha  = E_PROD_W'(in.q) * E_PROD_W'(in.half_h_a);
      s3_in.q_hwb  = E_PROD_W'(in.q) * E_PROD_W'(in.half_w_b);
      s3_in.q_hhb  = E_PROD_W'(in.q) * E_PROD_W'(in.half_h_b);
   end

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         s4_in.center_dist[i] = CMP_W'(s3_ff.d_mag[i]) << DIST_SHIFT;
      end
      // own box term along its own other axis is always zero
      s4_in.ext[0] = CMP_W'(s3_ff.na_hwa) + CMP_W'(s3_ff.p_hwb) + CMP_W'(s3_ff.q_hhb);
      s4_in.ext[1] = CMP_W'(s3_ff.na_hha) + CMP_W'(s3_ff.q_hwb) + CMP_W'(s3_ff.p_hhb);
      s4_in.ext[2] = CMP_W'(s3_ff.p_hwa) + CMP_W'(s3_ff.q_hha) + CMP_W'(s3_ff.nb_hwb);
      s4_in.ext[3] = CMP_W'(s3_ff.q_hwa) + CMP_W'(s3_ff.p_hha) + CMP_W'(s3_ff.nb_hhb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s3_ff <= s3_in;
      s4_ff <= s4_in;
   end

   assign out_valid = s4_valid_ff;
   assign out       = s4_ff;

endmodule

`default_nettype wire

>>> rtl/core/obb_sat_decide.sv
// stage five: per axis compare, first separating axis, result register
`default_nettype none

module obb_sat_decide
   import obb_sat_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  proj_out_type      in,
   output logic              out_valid,
   output logic              hit,
   output logic [AXIS_W-1:0] sep_axis
);

   logic [NUM_AXES-1:0] sep;
   logic                valid_in, valid_ff;
   logic                hit_in, hit_ff;
   logic [AXIS_W-1:0]   axis_in, axis_ff;

   assign valid_in = in_valid;

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         sep[i] = in.center_dist[i] > in.ext[i];
      end
      if (sep[0]) begin
         axis_in = AXIS_A_RIGHT;
      end else if (sep[1]) begin
         axis_in = AXIS_A_UP;
      end else if (sep[2]) begin
         axis_in = AXIS_B_RIGHT;
      end else if (sep[3]) begin
         axis_in = AXIS_B_UP;
      end else begin
         axis_in = AXIS_NONE;
      end
      hit_in = (sep == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff  <= hit_in;
      axis_ff <= axis_in;
   end

   assign out_valid = valid_ff;
   assign hit       = hit_ff;
   assign sep_axis  = axis_ff;

endmodule

`default_nettype wire
